// ----- sv/rqt_pkg.sv -----
// Shared types and constants for the quarter-turn frame rotator.
`timescale 1ns / 1ps

package rqt_pkg;

    localparam int PIXEL_BITS = 32;
    localparam int DIM_W      = 9;
    localparam int COORD_W    = 8;
    localparam int COUNT_W    = 2 * DIM_W;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUARTER_TURNS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_ROW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_END_ROW       = 3'd4;

    localparam logic [DIM_W-1:0] END_ROW_RESET = 9'd256;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_PUT  = 3'b100
    } t_state;

    typedef struct packed {
        logic accept;
        logic read;
        logic out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic emit;
        logic out_free;
    } t_ctrl_status;

endpackage

// ----- sv/rqt_ctrl.sv -----
// Controller state machine sequencing item acceptance, frame reads and result hand-off.
`timescale 1ns / 1ps

module rqt_ctrl
    import rqt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  t_ctrl_status i_status,
    output t_ctrl_cmd    o_cmd,
    output logic         o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_status.emit) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_PUT;
            end
            ST_PUT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.accept   = i_in_valid && (r_state == ST_IDLE);
    assign o_cmd.read     = (r_state == ST_READ);
    assign o_cmd.out_load = (r_state == ST_PUT) && i_status.out_free;
    assign o_in_stall     = (r_state != ST_IDLE);

endmodule

// ----- sv/rqt_datapath.sv -----
// Datapath: configuration registers, frame store, rotated address generation and output register.
`timescale 1ns / 1ps

module rqt_datapath
    import rqt_pkg::*;
#(
    parameter int MAX_DIM = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [DIM_W-1:0]      i_cfg_data,
    input  logic                  i_func,
    input  logic [PIXEL_BITS-1:0] i_pixel_in,
    input  t_ctrl_cmd             i_cmd,
    output t_ctrl_status          o_status,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [PIXEL_BITS-1:0] o_pixel_out,
    output logic [COORD_W-1:0]    o_dest_x,
    output logic [COORD_W-1:0]    o_dest_y,
    output logic                  o_band_done
);

    localparam int AW    = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
    localparam int DEPTH = 2 ** AW;
    localparam logic [DIM_W-1:0] DIM_CAP =
        (MAX_DIM > 511) ? 9'd511 : DIM_W'(MAX_DIM);

    logic [DIM_W-1:0]      r_width;
    logic [DIM_W-1:0]      r_height;
    logic [1:0]            r_turns;
    logic [DIM_W-1:0]      r_first_row;
    logic [DIM_W-1:0]      r_end_row;
    logic [COUNT_W-1:0]    r_load_count;
    logic [DIM_W-1:0]      r_out_col;
    logic [DIM_W-1:0]      r_out_row;
    logic                  r_band_finished;
    logic [COUNT_W-1:0]    n_load_count;
    logic [DIM_W-1:0]      n_out_col;
    logic [DIM_W-1:0]      n_out_row;
    logic                  n_band_finished;

    logic [PIXEL_BITS-1:0] r_frame [DEPTH];
    logic [AW-1:0]         r_addr;
    logic [PIXEL_BITS-1:0] r_rdata;
    logic [COORD_W-1:0]    r_hold_x;
    logic [COORD_W-1:0]    r_hold_y;
    logic                  r_hold_last;
    logic                  r_out_valid;
    logic [PIXEL_BITS-1:0] r_pixel_out;
    logic [COORD_W-1:0]    r_dest_x;
    logic [COORD_W-1:0]    r_dest_y;
    logic                  r_band_done;

    logic [DIM_W-1:0]      w;
    logic [DIM_W-1:0]      h;
    logic [COUNT_W-1:0]    total;
    logic [DIM_W-1:0]      out_w;
    logic [DIM_W-1:0]      out_h;
    logic [DIM_W-1:0]      band_end;
    logic                  frame_ready;
    logic                  in_band;
    logic                  emit;
    logic                  empty_band;
    logic [DIM_W:0]        col_next;
    logic [DIM_W:0]        row_next;
    logic                  wrap;
    logic                  last;
    logic [DIM_W-1:0]      sx;
    logic [DIM_W-1:0]      sy;
    logic [COUNT_W-1:0]    prod;
    logic [COUNT_W-1:0]    rd_index;
    logic [COUNT_W-1:0]    lc_eff;
    logic                  mem_we;

    assign w        = (r_width > DIM_CAP) ? DIM_CAP : r_width;
    assign h        = (r_height > DIM_CAP) ? DIM_CAP : r_height;
    assign total    = COUNT_W'(w) * COUNT_W'(h);
    assign out_w    = r_turns[0] ? h : w;
    assign out_h    = r_turns[0] ? w : h;
    assign band_end = (r_end_row < out_h) ? r_end_row : out_h;

    assign frame_ready = !r_band_finished && (r_load_count >= total);
    assign in_band     = (w != '0) && (h != '0) && (r_out_row < band_end) && (r_out_col < out_w);
    assign emit        = (i_func == FUNC_FETCH) && frame_ready && in_band;
    assign empty_band  = (i_func == FUNC_FETCH) && frame_ready && !in_band;

    assign col_next = {1'b0, r_out_col} + 1'b1;
    assign row_next = {1'b0, r_out_row} + 1'b1;
    assign wrap     = (col_next >= {1'b0, out_w});
    assign last     = wrap && (row_next >= {1'b0, band_end});

    always_comb begin
        case (r_turns)
            2'd0: begin
                sx = r_out_col;
                sy = r_out_row;
            end
            2'd1: begin
                sx = r_out_row;
                sy = h - 1'b1 - r_out_col;
            end
            2'd2: begin
                sx = w - 1'b1 - r_out_col;
                sy = h - 1'b1 - r_out_row;
            end
            default: begin
                sx = w - 1'b1 - r_out_row;
                sy = r_out_col;
            end
        endcase
    end

    assign prod     = COUNT_W'(sy) * COUNT_W'(w);
    assign rd_index = prod + COUNT_W'(sx);

    assign lc_eff = r_band_finished ? '0 : r_load_count;

    always_comb begin
        n_load_count    = r_load_count;
        n_out_col       = r_out_col;
        n_out_row       = r_out_row;
        n_band_finished = r_band_finished;
        mem_we          = 1'b0;
        if (i_cmd.accept) begin
            if (i_func == FUNC_LOAD) begin
                if (r_band_finished) begin
                    n_band_finished = 1'b0;
                    n_out_col       = '0;
                    n_out_row       = r_first_row;
                end
                n_load_count = lc_eff;
                if (lc_eff < total) begin
                    mem_we       = 1'b1;
                    n_load_count = lc_eff + 1'b1;
                end
            end else if (emit) begin
                if (wrap) begin
                    n_out_col = '0;
                    n_out_row = row_next[DIM_W-1:0];
                    if (last) begin
                        n_band_finished = 1'b1;
                    end
                end else begin
                    n_out_col = col_next[DIM_W-1:0];
                end
            end else if (empty_band) begin
                n_band_finished = 1'b1;
            end
        end
        if (i_cfg_valid && (i_cfg_index == REG_FIRST_ROW)) begin
            n_out_row = i_cfg_data;
            n_out_col = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width         <= '0;
            r_height        <= '0;
            r_turns         <= '0;
            r_first_row     <= '0;
            r_end_row       <= END_ROW_RESET;
            r_load_count    <= '0;
            r_out_col       <= '0;
            r_out_row       <= '0;
            r_band_finished <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_load_count    <= n_load_count;
            r_out_col       <= n_out_col;
            r_out_row       <= n_out_row;
            r_band_finished <= n_band_finished;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH:   r_width     <= i_cfg_data;
                    REG_IMAGE_HEIGHT:  r_height    <= i_cfg_data;
                    REG_QUARTER_TURNS: r_turns     <= i_cfg_data[1:0];
                    REG_FIRST_ROW:     r_first_row <= i_cfg_data;
                    REG_END_ROW:       r_end_row   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_frame[AW'(lc_eff)] <= i_pixel_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rdata <= r_frame[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && emit) begin
            r_addr      <= AW'(rd_index);
            r_hold_x    <= r_out_col[COORD_W-1:0];
            r_hold_y    <= r_out_row[COORD_W-1:0];
            r_hold_last <= last;
        end
        if (i_cmd.out_load) begin
            r_pixel_out <= r_rdata;
            r_dest_x    <= r_hold_x;
            r_dest_y    <= r_hold_y;
            r_band_done <= r_hold_last;
        end
    end

    assign o_status.emit     = emit;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_pixel_out = r_pixel_out;
    assign o_dest_x    = r_dest_x;
    assign o_dest_y    = r_dest_y;
    assign o_band_done = r_band_done;

endmodule

// ----- sv/rotate_by_quarter_turns.sv -----
// Top level of the quarter-turn frame rotator for RGBA8 images.
//
//   Channel  Direction  Handshake                Payload
//   in       sink       i_in_valid / o_in_stall  i_func, i_pixel_in
//   out      source     o_out_valid / i_out_stall  o_pixel_out, o_dest_x, o_dest_y, o_band_done
//   cfg      sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A load item, or a fetch item that gives no result, is accepted without leaving the idle state.
// A fetch item with a result goes through acceptance with address generation, the read of
// the frame memory, and the move into the output register.
// The move waits while the output register still holds an item that is stalled.
// Reset is synchronous; the frame memory is not cleared, so no clearing pass follows reset.
`timescale 1ns / 1ps

module rotate_by_quarter_turns
    import rqt_pkg::*;
#(
    parameter int MAX_DIM = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_func,
    input  logic [PIXEL_BITS-1:0] i_pixel_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PIXEL_BITS-1:0] o_pixel_out,
    output logic [COORD_W-1:0]    o_dest_x,
    output logic [COORD_W-1:0]    o_dest_y,
    output logic                  o_band_done,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [DIM_W-1:0]      i_cfg_data
);

    t_ctrl_cmd    cmd;
    t_ctrl_status status;

    assign o_cfg_ready = 1'b1;

    rqt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    rqt_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_func      (i_func),
        .i_pixel_in  (i_pixel_in),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_pixel_out (o_pixel_out),
        .o_dest_x    (o_dest_x),
        .o_dest_y    (o_dest_y),
        .o_band_done (o_band_done)
    );

    a_fetch_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.accept && status.emit) |=> (o_in_stall && cmd.read))
        else $error("A fetch with a result did not start a frame read.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out_valid || !i_out_stall))
        else $error("A waiting result was overwritten.");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_out_valid)
        else $error("A loaded result was not presented.");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.out_load))
        else $error("A result appeared without a load of the output register.");

endmodule
